FILE: src/rllt_pkg.sv
package rllt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam int unsigned LINE_W   = 16;
  localparam int unsigned COLUMN_W = 16;
  localparam int unsigned LENGTH_W = 8;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned INDEX_W  = 24;
  localparam int unsigned SLOT_OUT_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FIND  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_FIND
  } state_e;

  // One table entry as held by a cell.
  typedef struct packed {
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
    logic [COUNT_W-1:0]  count;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;
    logic append;
    logic merge;
  } cell_ctl_t;

endpackage

FILE: src/run_length_line_table.sv
// A write item returns its result in the cycle after it is accepted; a find item returns
// its result once the cell ring has made a full rotation past cell 0.
// Write items are taken one per cycle while no find is in progress. A find holds busy, so
// no new item is taken, until the full rotation of the cell ring past the single compare stage at cell 0 ends.
// Reset (rst_ni low, asynchronous) empties the table and clears the sequencer and strobe.
// Results are shown for one cycle under result_valid_o; the receiver cannot stall.
module run_length_line_table import rllt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op_i,
  input  logic [LINE_W-1:0]     run_line_i,
  input  logic [COLUMN_W-1:0]   run_column_i,
  input  logic [LENGTH_W-1:0]   run_length_i,
  input  logic [INDEX_W-1:0]    instruction_index_i,
  output logic                  result_valid_o,
  output logic                  found_o,
  output logic [LINE_W-1:0]     found_line_o,
  output logic [COLUMN_W-1:0]   found_column_o,
  output logic [SLOT_OUT_W-1:0] found_slot_o,
  output logic                  status_o
);

  // The slot counter indexes cells; the fill count must also hold TABLE_DEPTH itself.
  localparam int unsigned SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SUM_W  = COUNT_W + 1;

  // The table lives in a ring of cells, one entry each. Writes go straight into the
  // cell picked by the fill count. A find rotates the whole ring one place per cycle
  // toward cell 0, where a single adder keeps the running count; after TABLE_DEPTH
  // shifts every entry is back in its own cell.

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [SLOT_W-1:0]   step_q, step_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                hit_q, hit_d;
  logic [INDEX_W-1:0]  index_q, index_d;
  logic [LINE_W-1:0]   last_line_q, last_line_d;
  logic [COLUMN_W-1:0] last_column_q, last_column_d;

  logic                   res_valid_q, res_valid_d;
  logic                   res_found_q, res_found_d;
  logic [LINE_W-1:0]      res_line_q, res_line_d;
  logic [COLUMN_W-1:0]    res_column_q, res_column_d;
  logic [SLOT_OUT_W-1:0]  res_slot_q, res_slot_d;
  logic                   res_status_q, res_status_d;

  logic   accept;
  logic   wr_fire;
  logic   find_fire;
  logic   merge;
  logic   full;
  logic   append;
  logic   shift;
  logic   last_step;
  logic   head_active;
  logic [SUM_W-1:0] head_sum;
  logic   head_hit;
  entry_t wr_entry;
  entry_t head;

  entry_t    cell_q   [TABLE_DEPTH];
  cell_ctl_t cell_ctl [TABLE_DEPTH];

  assign accept    = start && !busy;
  assign wr_fire   = accept && (op_i == OP_WRITE);
  assign find_fire = accept && (op_i == OP_FIND);

  // A copy of the last entry's key decides merge against append without reading the ring.
  assign merge  = (used_q != '0) && (last_line_q == run_line_i)
                  && (last_column_q == run_column_i);
  assign full   = (used_q == CNT_W'(TABLE_DEPTH));
  assign append = wr_fire && !merge && !full;

  assign wr_entry.line   = run_line_i;
  assign wr_entry.column = run_column_i;
  assign wr_entry.count  = COUNT_W'(run_length_i);

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      assign cell_ctl[gi].shift  = shift;
      assign cell_ctl[gi].append = append && (used_q == CNT_W'(gi));
      assign cell_ctl[gi].merge  = wr_fire && merge && (used_q == CNT_W'(gi + 1));

      rllt_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (cell_ctl[gi]),
        .neighbor_i (cell_q[(gi + 1) % TABLE_DEPTH]),
        .wr_i       (wr_entry),
        .entry_o    (cell_q[gi])
      );
    end
  endgenerate

  assign head = cell_q[0];

  // During a find, the entry in cell 0 at step k is slot k. Slots at or beyond the fill
  // count and everything after the first hit are ignored. Before a hit the running sum
  // stays at or below the index, so SUM_W bits cannot wrap.
  assign last_step   = (step_q == SLOT_W'(TABLE_DEPTH - 1));
  assign head_active = (CNT_W'(step_q) < used_q) && !hit_q;
  assign head_sum    = sum_q + SUM_W'(head.count);
  assign head_hit    = head_active && (head_sum > SUM_W'(index_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (find_fire) begin
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        if (last_step) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy  = 1'b0;
    shift = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy  = 1'b0;
        shift = 1'b0;
      end
      ST_FIND: begin
        busy  = 1'b1;
        shift = 1'b1;
      end
      default: begin
        busy  = 1'b0;
        shift = 1'b0;
      end
    endcase
  end

  always_comb begin
    used_d        = used_q;
    last_line_d   = last_line_q;
    last_column_d = last_column_q;
    step_d        = step_q;
    sum_d         = sum_q;
    hit_d         = hit_q;
    index_d       = index_q;
    res_valid_d   = 1'b0;
    res_found_d   = res_found_q;
    res_line_d    = res_line_q;
    res_column_d  = res_column_q;
    res_slot_d    = res_slot_q;
    res_status_d  = res_status_q;

    if (append) begin
      used_d        = used_q + CNT_W'(1);
      last_line_d   = run_line_i;
      last_column_d = run_column_i;
    end

    if (wr_fire) begin
      res_valid_d  = 1'b1;
      res_found_d  = 1'b0;
      res_line_d   = '0;
      res_column_d = '0;
      res_slot_d   = '0;
      res_status_d = (!merge && full) ? STATUS_FULL : STATUS_OK;
    end

    if (find_fire) begin
      step_d       = '0;
      sum_d        = '0;
      hit_d        = 1'b0;
      index_d      = instruction_index_i;
      res_found_d  = 1'b0;
      res_line_d   = '0;
      res_column_d = '0;
      res_slot_d   = '0;
      res_status_d = STATUS_OK;
    end

    if (state_q == ST_FIND) begin
      step_d = step_q + SLOT_W'(1);
      if (head_active) begin
        sum_d = head_sum;
      end
      if (head_hit) begin
        hit_d        = 1'b1;
        res_found_d  = 1'b1;
        res_line_d   = head.line;
        res_column_d = head.column;
        res_slot_d   = SLOT_OUT_W'(step_q);
      end
      if (last_step) begin
        res_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q        <= step_d;
    sum_q         <= sum_d;
    hit_q         <= hit_d;
    index_q       <= index_d;
    last_line_q   <= last_line_d;
    last_column_q <= last_column_d;
    res_found_q   <= res_found_d;
    res_line_q    <= res_line_d;
    res_column_q  <= res_column_d;
    res_slot_q    <= res_slot_d;
    res_status_q  <= res_status_d;
  end

  assign result_valid_o = res_valid_q;
  assign found_o        = res_found_q;
  assign found_line_o   = res_line_q;
  assign found_column_o = res_column_q;
  assign found_slot_o   = res_slot_q;
  assign status_o       = res_status_q;

  // A write item always answers in the very next cycle.
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OP_WRITE) |=> result_valid_o)
    else $error("write item gave no result in the next cycle");

  // A result never shows while a find is still rotating the ring.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // The fill count never passes the table depth.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // A located entry never carries a full-table status.
  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && found_o) |-> (status_o == STATUS_OK))
    else $error("found result with error status");

endmodule

FILE: src/rllt_cell.sv
module rllt_cell import rllt_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  entry_t    neighbor_i,
  input  entry_t    wr_i,
  output entry_t    entry_o
);

  entry_t              entry_q;
  entry_t              entry_d;
  logic [COUNT_W:0]    sum;

  // Saturating merge of a run into this entry.
  assign sum = {1'b0, entry_q.count} + {1'b0, wr_i.count};

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = neighbor_i;
    end else if (ctl_i.append) begin
      entry_d = wr_i;
    end else if (ctl_i.merge) begin
      entry_d.count = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
